// ===== rtl/core/dkc_pkg.sv =====
// Shared types and constants for the dead-key compose engine.
package dkc_pkg;

  typedef struct packed {
    logic [31:0] key_code;
    logic [3:0]  modifiers;
  } dkc_in_t;

  typedef struct packed {
    logic       handled;
    logic       has_byte;
    logic [7:0] utf8_byte;
    logic       last;
  } dkc_out_t;

  // One classified key event: the handled flag and up to five commit bytes.
  typedef struct packed {
    logic            handled;
    logic [2:0]      nbytes;
    logic [4:0][7:0] bytes;
  } dkc_job_t;

  typedef enum logic [2:0] {
    ACC_NONE  = 3'd0,
    ACC_ACUTE = 3'd1,
    ACC_DIAER = 3'd2,
    ACC_GRAVE = 3'd3,
    ACC_CIRC  = 3'd4,
    ACC_TILDE = 3'd5
  } dkc_acc_t;

  localparam logic [31:0] KEY_BACKSPACE = 32'h0000_ff08;
  localparam logic [31:0] KEY_ESCAPE    = 32'h0000_ff1b;
  localparam logic [31:0] KEY_DELETE    = 32'h0000_ffff;
  localparam logic [31:0] KEY_INSERT    = 32'h0000_ff63;
  localparam logic [31:0] KEY_DEAD_GRV  = 32'h0000_fe50;
  localparam logic [31:0] KEY_DEAD_ACU  = 32'h0000_fe51;
  localparam logic [31:0] KEY_DEAD_CIR  = 32'h0000_fe52;
  localparam logic [31:0] KEY_DEAD_TIL  = 32'h0000_fe53;
  localparam logic [31:0] KEY_DEAD_DIA  = 32'h0000_fe57;
  localparam logic [31:0] UNI_BASE      = 32'h0100_0000;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

endpackage

// ===== rtl/core/dkc_front.sv =====
// Front end: accent state, key classification and UTF-8 encoding of the commit text.
module dkc_front import dkc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dkc_in_t  in_data,
  input  logic     q_full,
  output logic     q_push,
  output dkc_job_t q_data
);

  dkc_acc_t   acc_r, acc_nxt;
  logic [6:0] lit_r, lit_nxt;

  logic        rel, shortcut, is_accent, is_print, is_nav, rom_hit;
  dkc_acc_t    key_acc;
  logic [6:0]  key_lit;
  logic [20:0] cp;
  logic [7:0]  rom_cp;
  logic        pre_lit;
  logic        hnd;
  logic [20:0] enc_cp;
  logic [2:0]  enc_len;
  logic [3:0][7:0] enc;
  logic        fire;

  // Composed Latin-1 letter for an accent and an ASCII letter.
  function automatic logic [8:0] rom_lookup(input dkc_acc_t a, input logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    case (a)
      ACC_ACUTE: begin
        case (c)
          "a": r = 8'hE1; "A": r = 8'hC1; "c": r = 8'hE7; "C": r = 8'hC7;
          "e": r = 8'hE9; "E": r = 8'hC9; "i": r = 8'hED; "I": r = 8'hCD;
          "o": r = 8'hF3; "O": r = 8'hD3; "u": r = 8'hFA; "U": r = 8'hDA;
          "y": r = 8'hFD; "Y": r = 8'hDD;
          default: r = 8'h00;
        endcase
      end
      ACC_DIAER: begin
        case (c)
          "a": r = 8'hE4; "A": r = 8'hC4; "e": r = 8'hEB; "E": r = 8'hCB;
          "i": r = 8'hEF; "I": r = 8'hCF; "o": r = 8'hF6; "O": r = 8'hD6;
          "u": r = 8'hFC; "U": r = 8'hDC; "y": r = 8'hFF;
          default: r = 8'h00;
        endcase
      end
      ACC_GRAVE: begin
        case (c)
          "a": r = 8'hE0; "A": r = 8'hC0; "e": r = 8'hE8; "E": r = 8'hC8;
          "i": r = 8'hEC; "I": r = 8'hCC; "o": r = 8'hF2; "O": r = 8'hD2;
          "u": r = 8'hF9; "U": r = 8'hD9;
          default: r = 8'h00;
        endcase
      end
      ACC_CIRC: begin
        case (c)
          "a": r = 8'hE2; "A": r = 8'hC2; "e": r = 8'hEA; "E": r = 8'hCA;
          "i": r = 8'hEE; "I": r = 8'hCE; "o": r = 8'hF4; "O": r = 8'hD4;
          "u": r = 8'hFB; "U": r = 8'hDB;
          default: r = 8'h00;
        endcase
      end
      ACC_TILDE: begin
        case (c)
          "a": r = 8'hE3; "A": r = 8'hC3; "n": r = 8'hF1; "N": r = 8'hD1;
          "o": r = 8'hF5; "O": r = 8'hD5;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return {(r != 8'h00), r};
  endfunction

  assign fire     = in_valid && in_ready;
  assign in_ready = !q_full;
  assign q_push   = fire;
  assign rel      = in_data.modifiers[0];
  assign shortcut = |in_data.modifiers[3:1];

  always_comb begin
    is_accent = 1'b1;
    key_acc   = ACC_NONE;
    key_lit   = 7'h00;
    case (in_data.key_code)
      32'h27, KEY_DEAD_ACU: begin key_acc = ACC_ACUTE; key_lit = 7'h27; end
      32'h22, KEY_DEAD_DIA: begin key_acc = ACC_DIAER; key_lit = 7'h22; end
      32'h60, KEY_DEAD_GRV: begin key_acc = ACC_GRAVE; key_lit = 7'h60; end
      32'h5e, KEY_DEAD_CIR: begin key_acc = ACC_CIRC;  key_lit = 7'h5e; end
      32'h7e, KEY_DEAD_TIL: begin key_acc = ACC_TILDE; key_lit = 7'h7e; end
      default: is_accent = 1'b0;
    endcase
  end

  always_comb begin
    is_print = 1'b0;
    cp       = 21'h0;
    if (in_data.key_code inside {[32'h0000_0000 : 32'h0000_007f],
                                 [32'h0000_00a0 : 32'h0000_00ff]}) begin
      is_print = 1'b1;
      cp       = {13'h0, in_data.key_code[7:0]};
    end else if (in_data.key_code inside {[UNI_BASE + 32'h100 : UNI_BASE + 32'h10ffff]}) begin
      cp       = in_data.key_code[20:0];
      is_print = !(cp inside {[21'h00d800 : 21'h00dfff]});
    end
    is_nav = (in_data.key_code == KEY_DELETE) || (in_data.key_code == KEY_INSERT) ||
             (in_data.key_code inside {[32'h0000_ff50 : 32'h0000_ff57],
                                       [32'h0000_ffbe : 32'h0000_ffe0]});
    {rom_hit, rom_cp} = (cp[20:7] == 14'h0) ? rom_lookup(acc_r, cp[7:0]) : 9'h0;
  end

  // Decision per event: commit text is an optional literal and an optional code point.
  always_comb begin
    acc_nxt = acc_r;
    lit_nxt = lit_r;
    hnd     = 1'b0;
    pre_lit = 1'b0;
    enc_cp  = 21'h0;
    if (rel) begin
      hnd = 1'b0;
    end else if (acc_r == ACC_NONE) begin
      if (!shortcut && is_accent) begin
        acc_nxt = key_acc;
        lit_nxt = key_lit;
        hnd     = 1'b1;
      end
    end else if ((in_data.key_code == KEY_ESCAPE) || (in_data.key_code == KEY_BACKSPACE)) begin
      acc_nxt = ACC_NONE;
      lit_nxt = 7'h00;
      hnd     = 1'b1;
    end else if (shortcut) begin
      hnd = 1'b0;
    end else if (is_print) begin
      acc_nxt = ACC_NONE;
      lit_nxt = 7'h00;
      hnd     = 1'b1;
      if (cp == 21'h20) begin
        pre_lit = 1'b1;
      end else if (rom_hit) begin
        enc_cp = {13'h0, rom_cp};
      end else begin
        pre_lit = 1'b1;
        enc_cp  = cp;
      end
    end else if (is_nav) begin
      acc_nxt = ACC_NONE;
      lit_nxt = 7'h00;
      pre_lit = 1'b1;
    end
  end

  always_comb begin
    enc = '0;
    q_data.handled = hnd;
    if (enc_cp == 21'h0) begin
      enc_len = 3'd0;
    end else if (enc_cp < 21'h80) begin
      enc_len = 3'd1;
      enc[0]  = {1'b0, enc_cp[6:0]};
    end else if (enc_cp < 21'h800) begin
      enc_len = 3'd2;
      enc[0]  = {3'b110, enc_cp[10:6]};
      enc[1]  = {2'b10, enc_cp[5:0]};
    end else if (enc_cp < 21'h10000) begin
      enc_len = 3'd3;
      enc[0]  = {4'b1110, enc_cp[15:12]};
      enc[1]  = {2'b10, enc_cp[11:6]};
      enc[2]  = {2'b10, enc_cp[5:0]};
    end else begin
      enc_len = 3'd4;
      enc[0]  = {5'b11110, enc_cp[20:18]};
      enc[1]  = {2'b10, enc_cp[17:12]};
      enc[2]  = {2'b10, enc_cp[11:6]};
      enc[3]  = {2'b10, enc_cp[5:0]};
    end
    if (pre_lit) begin
      q_data.nbytes = enc_len + 3'd1;
      q_data.bytes  = {enc, {1'b0, lit_r}};
    end else begin
      q_data.nbytes = enc_len;
      q_data.bytes  = {8'h00, enc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ACC_NONE;
      lit_r <= 7'h00;
    end else if (fire) begin
      acc_r <= acc_nxt;
      lit_r <= lit_nxt;
    end
  end

  a_release_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data.modifiers[0] |=> $stable(acc_r) && $stable(lit_r))
    else $error("release beat changed the accent state");

  a_pending_has_literal: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r != ACC_NONE) |-> (lit_r != 7'h00))
    else $error("pending accent without a literal");

endmodule

// ===== rtl/core/dkc_fifo.sv =====
// Two-entry queue of classified events between the front and back ends.
module dkc_fifo import dkc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  dkc_job_t push_data,
  input  logic     pop,
  output dkc_job_t pop_data,
  output logic     full,
  output logic     not_empty
);

  dkc_job_t        mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QAW:0]    count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/core/dkc_back.sv =====
// Back end: plays out a queued event one UTF-8 byte per beat, or as one empty beat.
module dkc_back import dkc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_not_empty,
  input  dkc_job_t q_data,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output dkc_out_t out_data
);

  dkc_job_t   job_r;
  logic       busy_r;
  logic [2:0] idx_r;
  logic       is_last, out_fire;

  assign out_valid = busy_r;
  assign out_fire  = busy_r && out_ready;
  assign is_last   = (job_r.nbytes == 3'd0) || (idx_r + 3'd1 == job_r.nbytes);
  // A new event loads as soon as the current one has handed off its last beat.
  assign q_pop     = q_not_empty && (!busy_r || (out_fire && is_last));

  always_comb begin
    out_data.handled   = job_r.handled;
    out_data.has_byte  = (job_r.nbytes != 3'd0);
    out_data.utf8_byte = (job_r.nbytes != 3'd0) ? job_r.bytes[idx_r] : 8'h00;
    out_data.last      = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (out_fire) begin
      if (is_last) begin
        busy_r <= 1'b0;
        idx_r  <= 3'd0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
  end

  a_empty_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.last && (out_data.utf8_byte == 8'h00))
    else $error("beat without a byte is not the final beat");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (job_r.nbytes != 3'd0) |-> (idx_r < job_r.nbytes) && (job_r.nbytes <= 3'd5))
    else $error("byte index past the end of the commit text");

  a_stall_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_ready |=> $stable(idx_r) && busy_r)
    else $error("index moved while the result channel stalled");

endmodule

// ===== rtl/core/dead_key_compose_engine.sv =====
// A key beat passes the event queue and the back end's job register before its
// first result beat. One key event per cycle while out_ready is high and events give
// one beat; an event with commit text gives one beat per UTF-8 byte (one to five).
// A two-entry event queue lets the key side keep going while results stall.
// Reset (rst_n low, synchronous) clears the pending accent, the queue and out_valid.
module dead_key_compose_engine import dkc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dkc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dkc_out_t out_data
);

  logic     q_push, q_pop, q_full, q_not_empty;
  dkc_job_t push_job, pop_job;

  dkc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_job)
  );

  dkc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  dkc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
